### rtl/core/prsu_pkg.sv
// Package for the prefixed radix string to integer parser.
// Holds the character token type, phase codes and ASCII constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prsu_pkg;

  // Default result width and token queue depth.
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH         = 2;

  // ASCII codes the parser cares about.
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_O    = 8'h6f;
  localparam logic [7:0] CH_A_OFFSET = 8'h57;  // 'a' minus ten

  // Radix values, wide enough to hold sixteen.
  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  // Digit value of the letter 'b', which doubles as the binary prefix.
  localparam logic [3:0] DVAL_B = 4'd11;

  // Class of one character as seen by the front end.
  typedef enum logic [2:0] {
    TK_END,
    TK_DIGIT,
    TK_X,
    TK_O,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] dval;
  } token_t;

  // Parse phase of the back end.
  typedef enum logic [2:0] {
    PH_START,
    PH_ZERO,
    PH_DEC,
    PH_HEX,
    PH_BIN,
    PH_OCT,
    PH_ERR
  } phase_t;

endpackage

`default_nettype wire

### rtl/core/prsu_front.sv
// Front end: classifies one input character into a token.
// Depends on prsu_pkg for the token type and ASCII constants.
`timescale 1ns / 1ps
`default_nettype none

module prsu_front (
  input  wire logic [7:0]      char_code,
  output prsu_pkg::token_t     tok
);
  import prsu_pkg::*;

  logic [7:0] num_diff;
  logic [7:0] alpha_diff;

  assign num_diff   = char_code - CH_ZERO;
  assign alpha_diff = char_code - CH_A_OFFSET;

  // Sort the character into terminator, digit, prefix letter or other.
  always_comb begin
    tok.kind = TK_OTHER;
    tok.dval = '0;
    if (char_code == CH_NUL) begin
      tok.kind = TK_END;
    end else if (char_code inside {[CH_ZERO:CH_NINE]}) begin
      tok.kind = TK_DIGIT;
      tok.dval = num_diff[3:0];
    end else if (char_code inside {[CH_A:CH_F]}) begin
      tok.kind = TK_DIGIT;
      tok.dval = alpha_diff[3:0];
    end else if (char_code == CH_X) begin
      tok.kind = TK_X;
    end else if (char_code == CH_O) begin
      tok.kind = TK_O;
    end
  end

endmodule

`default_nettype wire

### rtl/core/prsu_queue.sv
// Short token queue between the front end and the back end.
// Depends on prsu_pkg for the token type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module prsu_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  prsu_pkg::token_t      push_tok,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output prsu_pkg::token_t      head_tok
);
  import prsu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  token_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == DEPTH_CNT);
  assign not_empty = (count_r != '0);
  assign head_tok  = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Token storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

### rtl/core/prsu_back.sv
// Back end: parse state machine, accumulator and result register.
// Depends on prsu_pkg for the token type and phase codes.
`timescale 1ns / 1ps
`default_nettype none

module prsu_back #(
  parameter int VALUE_WIDTH = prsu_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    tok_valid,
  input  prsu_pkg::token_t             tok,
  output logic                         tok_take,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [VALUE_WIDTH-1:0]       out_value,
  output logic                         out_failed
);
  import prsu_pkg::*;

  localparam int EXT_W = VALUE_WIDTH + 4;

  phase_t                  phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0]  acc_r, acc_nxt;
  logic                    err_r, err_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0]  out_value_r, out_value_nxt;
  logic                    out_failed_r, out_failed_nxt;

  logic                    out_free;
  logic                    is_end;
  logic [4:0]              radix;
  logic [EXT_W-1:0]        acc_ext;
  logic [EXT_W-1:0]        scaled;
  logic [EXT_W-1:0]        sum;
  logic                    digit_ok;
  logic                    good;
  logic                    fail_now;

  // A token is taken unless it is a terminator and the result register is busy.
  assign out_free = !out_valid_r || !out_stall;
  assign is_end   = (tok.kind == TK_END);
  assign tok_take = tok_valid && (!is_end || out_free);

  // Radix of the digit being taken in this phase.
  always_comb begin
    case (phase_r)
      PH_HEX:  radix = RADIX_HEX;
      PH_BIN:  radix = RADIX_BIN;
      PH_OCT:  radix = RADIX_OCT;
      default: radix = RADIX_DEC;
    endcase
  end

  // Shift-add by the radix; overflow shows in the top four bits.
  assign acc_ext = {4'b0, acc_r};
  always_comb begin
    case (phase_r)
      PH_HEX:  scaled = acc_ext << 4;
      PH_BIN:  scaled = acc_ext << 1;
      PH_OCT:  scaled = acc_ext << 3;
      default: scaled = (acc_ext << 3) + (acc_ext << 1);
    endcase
  end
  assign sum      = scaled + EXT_W'(tok.dval);
  assign digit_ok = (tok.kind == TK_DIGIT) && ({1'b0, tok.dval} < radix);
  assign good     = digit_ok && (sum[EXT_W-1:VALUE_WIDTH] == '0);
  assign fail_now = (phase_r == PH_ERR) || err_r;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (is_end) begin
      phase_nxt = PH_START;
    end else begin
      case (phase_r)
        PH_START: begin
          if (tok.kind == TK_DIGIT && tok.dval == '0) begin
            phase_nxt = PH_ZERO;
          end else begin
            phase_nxt = good ? PH_DEC : PH_ERR;
          end
        end
        PH_ZERO: begin
          if (tok.kind == TK_X) begin
            phase_nxt = PH_HEX;
          end else if (tok.kind == TK_O) begin
            phase_nxt = PH_OCT;
          end else if (tok.kind == TK_DIGIT && tok.dval == DVAL_B) begin
            phase_nxt = PH_BIN;
          end else begin
            phase_nxt = good ? PH_DEC : PH_ERR;
          end
        end
        PH_DEC, PH_HEX, PH_BIN, PH_OCT: begin
          phase_nxt = good ? phase_r : PH_ERR;
        end
        default: phase_nxt = PH_ERR;
      endcase
    end
  end

  // Accumulator, pending-failure flag and result.
  always_comb begin
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_failed_nxt = out_failed_r;
    if (is_end) begin
      acc_nxt        = '0;
      err_nxt        = 1'b0;
      out_valid_nxt  = tok_take || (out_valid_r && out_stall);
      out_value_nxt  = fail_now ? '0 : acc_r;
      out_failed_nxt = fail_now;
    end else begin
      case (phase_r)
        PH_START: begin
          if (!(tok.kind == TK_DIGIT && tok.dval == '0)) begin
            acc_nxt = good ? sum[VALUE_WIDTH-1:0] : '0;
            err_nxt = !good;
          end
        end
        PH_ZERO: begin
          if (tok.kind == TK_X || tok.kind == TK_O ||
              (tok.kind == TK_DIGIT && tok.dval == DVAL_B)) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = good ? sum[VALUE_WIDTH-1:0] : '0;
            err_nxt = !good;
          end
        end
        PH_DEC, PH_HEX, PH_BIN, PH_OCT: begin
          acc_nxt = good ? sum[VALUE_WIDTH-1:0] : '0;
          err_nxt = !good;
        end
        default: begin
          acc_nxt = '0;
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  // Phase, accumulator and error flag update only on a token transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      acc_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tok_take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        err_r   <= err_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads on a terminator.
  always_ff @(posedge clk) begin
    if (tok_take && is_end) begin
      out_value_r  <= out_value_nxt;
      out_failed_r <= out_failed_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_failed = out_failed_r;

endmodule

`default_nettype wire

### rtl/core/prefixed_radix_string_to_uint_unit.sv
// Top level of the prefixed radix string to unsigned integer parser.
// Depends on prsu_pkg, prsu_front, prsu_queue and prsu_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one ASCII character per transfer and returns one result per zero byte.
// A leading "0x", "0b" or "0o" selects hex, binary or octal (lowercase only);
// otherwise the string is decimal. A failed parse (illegal character, empty
// prefixed body or overflow past VALUE_WIDTH bits) gives value 0 with failed
// set. One character is accepted every cycle unless the token queue is full:
// the back end's combinational shift-add and overflow compare sets that rate.
// A terminator passes through the token queue before the back end loads its
// result register, waiting while an earlier result is held under stall.
// Characters keep flowing while a result waits, until the next terminator
// reaches the back end; then the two-entry token queue fills and the input stalls.

module prefixed_radix_string_to_uint_unit #(
  parameter int VALUE_WIDTH = prsu_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_char_code,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [VALUE_WIDTH-1:0]       out_value,
  output logic                         out_failed
);
  import prsu_pkg::*;

  token_t front_tok;
  token_t head_tok;
  logic   q_full;
  logic   q_not_empty;
  logic   tok_take;
  logic   in_xfer;

  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  // Character classification.
  prsu_front u_front (
    .char_code (in_char_code),
    .tok       (front_tok)
  );

  // Token queue between the two halves.
  prsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (tok_take),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  // Parser state machine and result register.
  prsu_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (q_not_empty),
    .tok        (head_tok),
    .tok_take   (tok_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_failed (out_failed)
  );

`ifndef SYNTHESIS
  // A failed result always carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failed |-> out_value == '0)
    else $error("failed result with nonzero value");

  // The back end never takes a token from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    tok_take |-> q_not_empty)
    else $error("token taken from empty queue");

  // A result held under stall is replaced only after it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_failed))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### tb/prsu_result_checker.sv
// Result checker for the prefixed radix string to unsigned integer parser.
// Depends on prsu_pkg for phase codes and ASCII constants; watches both channels of the unit.
`timescale 1ns / 1ps

module prsu_result_checker #(
  parameter int VALUE_WIDTH = prsu_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_char_code,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [VALUE_WIDTH-1:0] out_value,
  input  logic                   out_failed,
  output int                     mismatches,
  output int                     pending
);

  import prsu_pkg::*;

  // The package has no code for the binary prefix letter.
  localparam logic [7:0] CH_B = 8'h62;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   failed;
  } parse_result_t;

  // Parse results owed by the unit, oldest first.
  parse_result_t   expected_results[$];
  parse_result_t   oldest;

  // Shadow copy of the parse state.
  phase_t          parse_phase;
  longint unsigned parse_acc;
  logic            body_missing;
  int              fail_tally = 0;

  task automatic restart_string();
    parse_phase  = PH_START;
    parse_acc    = 0;
    body_missing = 1'b0;
  endtask

  task automatic enter_error();
    parse_phase  = PH_ERR;
    parse_acc    = 0;
    body_missing = 1'b1;
  endtask

  // Shift one digit into the value; an invalid character or an overflow poisons the string.
  task automatic fold_digit(input logic [7:0] c, input int unsigned radix,
                            input phase_t next_phase);
    int unsigned     digit;
    longint unsigned grown;
    digit = radix;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = c - CH_ZERO;
    end else if (radix == RADIX_HEX && c >= CH_A && c <= CH_F) begin
      digit = c - CH_A + 10;
    end
    grown = parse_acc * radix + digit;
    if (digit >= radix || grown > VALUE_MAX) begin
      enter_error();
    end else begin
      parse_acc    = grown;
      body_missing = 1'b0;
      parse_phase  = next_phase;
    end
  endtask

  // Advance the shadow state by one character; a zero byte queues a result.
  task automatic absorb_char(input logic [7:0] c);
    parse_result_t r;
    if (c == CH_NUL) begin
      r.failed = (parse_phase == PH_ERR) || body_missing;
      r.value  = r.failed ? '0 : parse_acc[VALUE_WIDTH-1:0];
      expected_results.push_back(r);
      restart_string();
    end else begin
      case (parse_phase)
        PH_START: begin
          if (c == CH_ZERO) parse_phase = PH_ZERO;
          else fold_digit(c, RADIX_DEC, PH_DEC);
        end
        PH_ZERO: begin
          if (c == CH_X) begin
            parse_phase  = PH_HEX;
            body_missing = 1'b1;
          end else if (c == CH_B) begin
            parse_phase  = PH_BIN;
            body_missing = 1'b1;
          end else if (c == CH_O) begin
            parse_phase  = PH_OCT;
            body_missing = 1'b1;
          end else begin
            fold_digit(c, RADIX_DEC, PH_DEC);
          end
        end
        PH_DEC: fold_digit(c, RADIX_DEC, PH_DEC);
        PH_HEX: fold_digit(c, RADIX_HEX, PH_HEX);
        PH_BIN: fold_digit(c, RADIX_BIN, PH_BIN);
        PH_OCT: fold_digit(c, RADIX_OCT, PH_OCT);
        default: enter_error();
      endcase
    end
  endtask

  // Results are compared before the character of the same edge is absorbed;
  // a result always trails the transfer of its terminator.
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_string();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: value %0h failed %0b", out_value, out_failed);
          fail_tally++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_value !== oldest.value) begin
            $error("value: expected %0h, actual %0h", oldest.value, out_value);
            fail_tally++;
          end
          if (out_failed !== oldest.failed) begin
            $error("failed: expected %0b, actual %0b", oldest.failed, out_failed);
            fail_tally++;
          end
        end
      end
      if (in_valid && !in_stall) absorb_char(in_char_code);
    end
    pending    <= expected_results.size();
    mismatches <= fail_tally;
  end

endmodule

### tb/tb_prefixed_radix_string_to_uint_unit.sv
// Testbench top for the prefixed radix string to unsigned integer parser.
// Depends on prsu_pkg, the unit under test and prsu_result_checker; drives strings and rules.
`timescale 1ns / 1ps

module tb_prefixed_radix_string_to_uint_unit;

  import prsu_pkg::*;

  localparam int VALUE_WIDTH    = VALUE_WIDTH_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_CHARS    = 450;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic [7:0]             in_char_code = CH_NUL;
  logic                   out_stall    = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_value;
  logic                   out_failed;

  int mismatches;
  int pending;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int chars_sent  = 0;
  int idle_cycles = 0;

  // Characters of the string being built, terminator not included.
  logic [7:0] text_q[$];
  string      digit_set = "0123456789abcdef";

  initial begin
    forever #1 clk = ~clk;
  end

  prefixed_radix_string_to_uint_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_failed(out_failed)
  );

  prsu_result_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_failed(out_failed),
    .mismatches(mismatches),
    .pending(pending)
  );

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // End the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_prefixed_radix_string_to_uint_unit: errors");
      $finish;
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_digits(input int unsigned radix, input int unsigned count);
    for (int i = 0; i < count; i++) text_q.push_back(digit_set[$urandom_range(radix - 1)]);
  endfunction

  // Mostly well-formed numbers of every base, with boundary values,
  // corrupted strings, raw noise, bare prefixes and uppercase letters mixed in.
  function automatic void compose_string();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      if ($urandom_range(9) == 0) add_text("0");
      add_digits(10, ($urandom_range(3) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 4));
    end else if (pick < 34) begin
      add_text("0x");
      add_digits(16, ($urandom_range(3) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 4));
    end else if (pick < 46) begin
      add_text("0b");
      add_digits(2, ($urandom_range(4) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 10));
    end else if (pick < 58) begin
      add_text("0o");
      add_digits(8, ($urandom_range(3) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4));
    end else if (pick < 70) begin
      case ($urandom_range(7))
        0: add_text("4294967295");
        1: add_text("4294967296");
        2: begin
          add_text("42949672");
          add_digits(10, 2);
        end
        3: add_text("0xffffffff");
        4: add_text("0x100000000");
        5: begin
          add_text("0b");
          repeat (32) add_text("1");
          if ($urandom_range(1) == 1) add_text("0");
        end
        6: add_text("0o37777777777");
        default: add_text("0o40000000000");
      endcase
    end else if (pick < 80) begin
      if ($urandom_range(1) == 1) begin
        add_text("0x");
        add_digits(16, $urandom_range(1, 6));
      end else begin
        add_digits(10, $urandom_range(1, 6));
      end
      text_q[$urandom_range(text_q.size() - 1)] = $urandom_range(1, 255);
    end else if (pick < 88) begin
      repeat ($urandom_range(4)) text_q.push_back($urandom_range(1, 255));
    end else if (pick < 94) begin
      case ($urandom_range(4))
        0: add_text("");
        1: add_text("0");
        2: add_text("0x");
        3: add_text("0b");
        default: add_text("0o");
      endcase
    end else begin
      case ($urandom_range(3))
        0: add_text("0X1");
        1: add_text("0B1");
        2: add_text("0O7");
        default: begin
          add_text("0x");
          text_q.push_back($urandom_range(8'h41, 8'h46));
        end
      endcase
    end
  endfunction

  // One character transfer, after an optional random gap.
  task automatic put_char(input logic [7:0] c);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!(in_valid && !in_stall));
    chars_sent++;
  endtask

  // Send the built string followed by its terminator.
  task automatic send_text();
    foreach (text_q[i]) put_char(text_q[i]);
    put_char(CH_NUL);
    text_q.delete();
  endtask

  // Hold the sender off until every owed result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    string special_cases[] = '{"", "0", "0x", "0b", "0o", "0x100000000"};
    int    target;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: empty, lone zero, bare prefixes, overflow, and an
    // uppercase prefix followed by the top code point.
    foreach (special_cases[i]) begin
      add_text(special_cases[i]);
      send_text();
    end
    add_text("0X");
    text_q.push_back(8'hff);
    send_text();
    drain_results();

    // Random strings under four idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 47;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 47;
        end
        default: begin
          gap_pct = 27;
          stall_pct <= 27;
        end
      endcase
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) begin
        compose_string();
        send_text();
      end
      drain_results();
    end

    // Let any stray result surface before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_prefixed_radix_string_to_uint_unit: clean");
    end else begin
      $display("tb_prefixed_radix_string_to_uint_unit: errors");
    end
    $finish;
  end

endmodule
